[src/assert_macros.svh]
// Assertion macros used by the checker of the sort engine.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define AST_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/ise_pkg.sv]
// Shared types and constants for the insertion sort engine.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package ise_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_BITS = 16;
    localparam int VAL_W    = 16;
    localparam int CMP_W    = 12;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [CMP_W-1:0]    t_cmp;

    localparam t_cmp CMP_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK_RD,
        S_PICK_WAIT,
        S_CMP,
        S_PLACE,
        S_OUT_RD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_pick;
        logic take_pick;
        logic shift;
        logic place;
        logic next_out;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_done;
        logic le;
        logic pos_one;
        logic k_last;
    } t_status;

endpackage

`default_nettype wire

[src/ise_datapath.sv]
// Datapath of the sort engine: key memory, sort indexes, pick register and counters.
// Depends on ise_pkg; driven by the command word of ise_ctrl.
`default_nettype none

module ise_datapath import ise_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_value,
    output t_status          o_status,
    output logic [VAL_W-1:0] o_sorted_value,
    output logic [CMP_W-1:0] o_comparisons,
    output logic             o_dropped
);

    t_key r_mem [MAX_KEYS];
    t_key r_rdata;
    t_key r_pick;
    t_cnt r_count;
    t_cnt r_i;
    t_idx r_pos;
    t_idx r_k;
    t_cmp r_cmp;
    logic r_overflow;

    t_cnt n_count;
    t_cmp n_cmp;
    logic n_overflow;

    logic room;
    logic wr_en;
    t_idx wr_addr;
    t_key wr_data;
    t_idx rd_addr;

    assign room = r_count < CNT_W'(MAX_KEYS);

    // Single write port: load, shift of an entry up one place, or final placement.
    always_comb begin
        wr_en   = (i_cmd.load && room) || i_cmd.shift || i_cmd.place;
        wr_addr = i_cmd.load ? r_count[IDX_W-1:0] : r_pos;
        if (i_cmd.load) begin
            wr_data = KEY_BITS'(i_value);
        end else if (i_cmd.shift) begin
            wr_data = r_rdata;
        end else begin
            wr_data = r_pick;
        end
    end

    // Single read port. While shifting, the entry below the next hole is fetched
    // so that one shift completes every cycle.
    always_comb begin
        if (i_cmd.rd_pick) begin
            rd_addr = r_i[IDX_W-1:0];
        end else if (i_cmd.take_pick) begin
            rd_addr = r_pos - IDX_W'(1);
        end else if (i_cmd.shift) begin
            rd_addr = r_pos - IDX_W'(2);
        end else begin
            rd_addr = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_count    = r_count;
        n_cmp      = r_cmp;
        n_overflow = r_overflow;
        if (i_cmd.load) begin
            if (room) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_overflow = 1'b1;
            end
        end
        if ((i_cmd.shift || i_cmd.place) && (r_cmp != CMP_MAX)) begin
            n_cmp = r_cmp + CMP_W'(1);
        end
        if (i_cmd.finish) begin
            n_count    = '0;
            n_cmp      = '0;
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cmp      <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_cmp      <= n_cmp;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_i <= CNT_W'(1);
            r_k <= '0;
        end else if (i_cmd.place) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (i_cmd.rd_pick) begin
            r_pos <= r_i[IDX_W-1:0];
        end else if (i_cmd.shift) begin
            r_pos <= r_pos - IDX_W'(1);
        end
        if (i_cmd.take_pick) begin
            r_pick <= r_rdata;
        end
        if (i_cmd.next_out) begin
            r_k <= r_k + IDX_W'(1);
        end
    end

    always_comb begin
        o_status.i_done  = r_i >= r_count;
        o_status.le      = r_pick <= r_rdata;
        o_status.pos_one = r_pos == IDX_W'(1);
        o_status.k_last  = (CNT_W'(r_k) + CNT_W'(1)) == r_count;
    end

    assign o_sorted_value = VAL_W'(r_rdata);
    assign o_comparisons  = r_cmp;
    assign o_dropped      = r_overflow;

endmodule

`default_nettype wire

[src/ise_ctrl.sv]
// Controller of the sort engine: sequences loading, the insertion passes and output.
// Depends on ise_pkg; issues the command word for ise_datapath.
`default_nettype none

module ise_ctrl import ise_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_last) begin
                    n_state = S_PICK_RD;
                end
            end
            S_PICK_RD: begin
                n_state = i_status.i_done ? S_OUT_RD : S_PICK_WAIT;
            end
            S_PICK_WAIT: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_status.le) begin
                    n_state = S_PICK_RD;
                end else if (i_status.pos_one) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = S_PICK_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = i_status.k_last ? S_IDLE : S_OUT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_PICK_RD: begin
                o_cmd.rd_pick = !i_status.i_done;
            end
            S_PICK_WAIT: begin
                o_cmd.take_pick = 1'b1;
            end
            S_CMP: begin
                o_cmd.shift = i_status.le;
                o_cmd.place = !i_status.le;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
            end
            S_OUT_RD: begin
            end
            S_OUT: begin
                o_valid        = 1'b1;
                o_cmd.next_out = !i_status.k_last;
                o_cmd.finish   = i_status.k_last;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[src/insertion_sort_engine.sv]
// Insertion sort engine.
// Input: a word is taken at a clock edge with start high and busy low. Each word carries
// i_value and i_last; i_last closes the set. Up to MAX_KEYS (64) words are stored,
// further words of the set are discarded and o_dropped is raised on its results.
// A word that does not close the set leaves busy low.
// After the closing word the keys are sorted in place in a key memory with one read
// and one write port. Each key in turn is read into the pick register and compared
// with the earlier keys from the top down; each larger or equal key is shifted up one
// place until a smaller key or the bottom is reached, and the key is then placed.
// Output: the n sorted words then follow, each shown for one cycle with o_valid high;
// o_final_res marks the last one. o_comparisons and o_dropped are the same on all
// results of a set. busy is high from the closing word until the cycle after the last
// result; the receiver cannot stall and must take every word.
// Reset (synchronous, active low) empties the open set and returns to idle; the
// key memory is not cleared since only written entries are read.
// Depends on ise_pkg, ise_ctrl and ise_datapath.
`default_nettype none

module insertion_sort_engine import ise_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_last,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_sorted_value,
    output logic             o_final_res,
    output logic [CMP_W-1:0] o_comparisons,
    output logic             o_dropped
);

    t_cmd    cmd;
    t_status status;

    ise_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_last   (i_last),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    ise_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_status       (status),
        .o_sorted_value (o_sorted_value),
        .o_comparisons  (o_comparisons),
        .o_dropped      (o_dropped)
    );

    assign o_final_res = status.k_last;

endmodule

`default_nettype wire

[src/ise_checker.sv]
// Port-level checker for the insertion sort engine, bound to the top level.
// Depends on ise_pkg and the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ise_checker import ise_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             i_last,
    input wire logic             o_valid,
    input wire logic             o_final_res,
    input wire logic [CMP_W-1:0] o_comparisons
);

    // Results only appear while a set is being processed.
    `AST_SAME(a_valid_busy, i_clk, i_rst_n, o_valid, busy)

    // Reset leaves the engine idle with no result pending.
    `AST_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !busy && !o_valid)

    // A word that does not close the set keeps the engine ready.
    `AST_NEXT(a_open_set, i_clk, i_rst_n, start && !busy && !i_last, !busy)

    // The final word of a set returns the engine to idle.
    `AST_NEXT(a_final_idle, i_clk, i_rst_n, o_valid && o_final_res, !busy && !o_valid)

    // Non-final words are followed by another word with the same count.
    `AST_NEXT(a_next_word, i_clk, i_rst_n, o_valid && !o_final_res, ##1 (o_valid && o_comparisons == $past(o_comparisons, 2)))

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (.*);

`default_nettype wire
